### sv/spmf_pkg.sv
// package for the strict priority multi fifo unit
// sizes, status codes and the result control struct; no dependencies

package spmf_pkg;

  // configuration of the queue set
  localparam int Levels   = 4;
  localparam int Depth    = 16;
  localparam int TagWidth = 32;

  // fixed field widths of the word format
  localparam int CmdW      = 1;
  localparam int LevelW    = 2;
  localparam int TagFieldW = 32;
  localparam int LenW      = 8;
  localparam int StatusW   = 2;
  localparam int CountW    = 7;

  // derived sizes
  localparam int LvlW  = $clog2(Levels);
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int TotW  = $clog2(Levels * Depth + 1);
  localparam int AddrW = $clog2(Levels * Depth);

  localparam logic [LenW-1:0] NameLimit = LenW'(20);

  typedef enum logic [CmdW-1:0] {
    CmdAdmit = 1'b0,
    CmdNext  = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StTooLong = 2'd1,
    StFull    = 2'd2,
    StEmpty   = 2'd3
  } status_e;

  // control half of a result, travels beside the ram read
  typedef struct packed {
    status_e             status;
    logic [LevelW-1:0]   level;
    logic [CountW-1:0]   count;
    logic                take;
  } res_t;

endpackage

### sv/spmf_in_if.sv
// request channel of the strict priority multi fifo unit
// depends on spmf_pkg

interface spmf_in_if;
  logic                          valid;
  logic                          ready;
  logic [spmf_pkg::CmdW-1:0]      command;
  logic [spmf_pkg::LevelW-1:0]    level;
  logic [spmf_pkg::TagFieldW-1:0] entry_tag;
  logic [spmf_pkg::LenW-1:0]      tag_length;

  modport source (output valid, command, level, entry_tag, tag_length, input ready);
  modport sink   (input valid, command, level, entry_tag, tag_length, output ready);
endinterface

### sv/spmf_out_if.sv
// response channel of the strict priority multi fifo unit
// depends on spmf_pkg

interface spmf_out_if;
  logic                          valid;
  logic                          ready;
  logic [spmf_pkg::StatusW-1:0]   status;
  logic [spmf_pkg::TagFieldW-1:0] out_tag;
  logic [spmf_pkg::LevelW-1:0]    out_level;
  logic [spmf_pkg::CountW-1:0]    total_count;

  modport source (output valid, status, out_tag, out_level, total_count, input ready);
  modport sink   (input valid, status, out_tag, out_level, total_count, output ready);
endinterface

### sv/strict_priority_multi_fifo_unit.sv
// top level of the strict priority multi fifo unit
// depends on spmf_pkg, spmf_in_if, spmf_out_if, spmf_ram and spmf_ctrl
//
//  port    | dir | word content
//  --------+-----+------------------------------------------------------
//  req_i   | in  | command, level, entry_tag, tag_length
//  rsp_o   | out | status, out_tag, out_level, total_count
//
//  one word accepted per cycle while ready is high, one response word per request word
//  the tag ram read port sets the first stage of a request's path,
//  the response register the second
//  reset (rst_ni low) empties every level; tag ram contents are not cleared
//  a stalled response holds in the output register while one more request
//  is taken into the middle stage; ready drops only when both are full

module strict_priority_multi_fifo_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  spmf_in_if.sink         req_i,
  spmf_out_if.source      rsp_o
);
  import spmf_pkg::*;

  // handshake
  logic accept;
  logic s1_adv;

  // tag ram ports
  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [TagWidth-1:0] ram_wdata, ram_rdata;

  // middle stage: control half of the result, tag comes from the ram read register
  res_t res;
  logic s1_valid_q, s1_valid_d;
  res_t s1_res_q;

  // response register
  logic                 out_valid_q, out_valid_d;
  logic [StatusW-1:0]   out_status_q;
  logic [TagFieldW-1:0] out_tag_q;
  logic [LevelW-1:0]    out_level_q;
  logic [CountW-1:0]    out_count_q;

  // middle stage moves on when the response register is free or draining
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  spmf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (req_i.command),
    .level_i      (req_i.level),
    .entry_tag_i  (req_i.entry_tag),
    .tag_length_i (req_i.tag_length),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .res_o        (res)
  );

  // read data register holds while the middle stage waits, no new read can start then
  spmf_ram #(
    .Width (TagWidth),
    .Depth (Levels * Depth)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_adv) begin
      out_status_q <= s1_res_q.status;
      out_level_q  <= s1_res_q.level;
      out_count_q  <= s1_res_q.count;
      // admit and empty results carry a zero tag
      out_tag_q    <= s1_res_q.take ? TagFieldW'(ram_rdata) : '0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_tag     = out_tag_q;
  assign rsp_o.out_level   = out_level_q;
  assign rsp_o.total_count = out_count_q;

  // an accepted word always sits in the middle stage on the next cycle
  a_accept_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted word missing from middle stage");

  // a taken entry always reports success
  a_take_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_res_q.take) |-> (s1_res_q.status == StOk))
    else $error("take without ok status");

  // an empty report means nothing is held
  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == StEmpty) |-> (out_count_q == '0))
    else $error("empty status with nonzero count");

  // only successful words carry a tag
  a_tag_only_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tag_q != '0) |-> (out_status_q == StOk))
    else $error("nonzero tag on a refused or empty result");

  // middle stage can only be refilled when it drains or is empty
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !accept)
    else $error("middle stage overwritten");

endmodule

### sv/spmf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module spmf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/spmf_ctrl.sv
// ring pointers, per level counts and the priority pick
// depends on spmf_pkg; drives the tag ram ports

module spmf_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [spmf_pkg::CmdW-1:0]       command_i,
  input  logic [spmf_pkg::LevelW-1:0]     level_i,
  input  logic [spmf_pkg::TagFieldW-1:0]  entry_tag_i,
  input  logic [spmf_pkg::LenW-1:0]       tag_length_i,
  output logic                            ram_we_o,
  output logic [spmf_pkg::AddrW-1:0]      ram_waddr_o,
  output logic [spmf_pkg::TagWidth-1:0]   ram_wdata_o,
  output logic                            ram_re_o,
  output logic [spmf_pkg::AddrW-1:0]      ram_raddr_o,
  output spmf_pkg::res_t                  res_o
);
  import spmf_pkg::*;

  logic [PtrW-1:0] head_q [Levels];
  logic [PtrW-1:0] head_d [Levels];
  logic [PtrW-1:0] tail_q [Levels];
  logic [PtrW-1:0] tail_d [Levels];
  logic [CntW-1:0] cnt_q  [Levels];
  logic [CntW-1:0] cnt_d  [Levels];
  logic [TotW-1:0] total_q, total_d;

  logic [LvlW-1:0] lvl_idx, sel_lvl;
  logic            lvl_ok, found;
  logic [PtrW-1:0] slot;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  // highest non-empty level wins
  always_comb begin
    found   = 1'b0;
    sel_lvl = '0;
    for (int i = 0; i < Levels; i++) begin
      if (cnt_q[i] != '0) begin
        found   = 1'b1;
        sel_lvl = LvlW'(i);
      end
    end
  end

  assign lvl_idx = LvlW'(level_i);
  assign lvl_ok  = (int'(level_i) < Levels);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    total_d      = total_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ram_waddr_o  = '0;
    ram_raddr_o  = '0;
    ram_wdata_o  = TagWidth'(entry_tag_i);
    slot         = '0;
    res_o.status = StOk;
    res_o.level  = '0;
    res_o.take   = 1'b0;
    if (accept_i) begin
      if (cmd_e'(command_i) == CmdAdmit) begin
        if (tag_length_i > NameLimit) begin
          res_o.status = StTooLong;
        end else if (!lvl_ok || cnt_q[lvl_idx] >= CntW'(Depth)) begin
          res_o.status = StFull;
        end else begin
          slot            = tail_q[lvl_idx];
          ram_we_o        = 1'b1;
          ram_waddr_o     = AddrW'(lvl_idx) * AddrW'(Depth) + AddrW'(slot);
          tail_d[lvl_idx] = ring_next(slot);
          cnt_d[lvl_idx]  = cnt_q[lvl_idx] + 1'b1;
          total_d         = total_q + 1'b1;
        end
      end else begin
        if (!found) begin
          res_o.status = StEmpty;
        end else begin
          slot            = head_q[sel_lvl];
          ram_re_o        = 1'b1;
          ram_raddr_o     = AddrW'(sel_lvl) * AddrW'(Depth) + AddrW'(slot);
          head_d[sel_lvl] = ring_next(slot);
          cnt_d[sel_lvl]  = cnt_q[sel_lvl] - 1'b1;
          if (total_q != '0) begin
            total_d = total_q - 1'b1;
          end
          res_o.level = LevelW'(sel_lvl);
          res_o.take  = 1'b1;
        end
      end
    end
    res_o.count = CountW'(total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Levels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      total_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
    end
  end

endmodule
